FILE: hdl/acfp_pkg.sv
// ----------------------------------------------------------------------------
// acfp_pkg
// Shared constants and types for the ASCII command frame parser.
// ----------------------------------------------------------------------------
package acfp_pkg;

	// Frame opening and special characters.
	localparam logic [7:0] CH_AT    = 8'h40; // '@' opens a dosing frame
	localparam logic [7:0] CH_P     = 8'h50; // 'P' opens a wash frame
	localparam logic [7:0] CH_EQ    = 8'h3D; // '=' opens a start frame
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_TWO   = 8'h32;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// Digits in each parameter frame.
	localparam logic [3:0] DOSE_LEN = 4'd14;
	localparam logic [3:0] WASH_LEN = 4'd11;

	// Digit positions where each field ends (inclusive).
	localparam logic [3:0] POS_MODE   = 4'd0;
	localparam logic [3:0] POS_VOLUME = 4'd4;
	localparam logic [3:0] POS_SPEED  = 4'd7;
	localparam logic [3:0] POS_RATIO  = 4'd10;

	// Result frame kinds.
	localparam logic [1:0] KIND_DOSE    = 2'd0;
	localparam logic [1:0] KIND_WASH    = 2'd1;
	localparam logic [1:0] KIND_START   = 2'd2;
	localparam logic [1:0] KIND_UNKNOWN = 2'd3;

	localparam logic [3:0] RESET_MODE = 4'd2;

	// One stored parameter set.
	typedef struct packed {
		logic [3:0]  mode;
		logic [13:0] volume;
		logic [9:0]  speed;
		logic [9:0]  ratio;
		logic [9:0]  reverse;
	} param_set_t;

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= CH_ZERO) && (b <= CH_NINE);
	endfunction

endpackage

FILE: hdl/ascii_command_frame_parser.sv
// ----------------------------------------------------------------------------
// ascii_command_frame_parser
// Parses received serial bytes into dosing, wash and start command frames
// and reports one ack or nack beat, with the stored values, per frame and per stray byte.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake           | Payload
//  --------+-----------+---------------------+-----------------------------------
//  input   | in        | in_valid, in_stall  | rx_byte
//  result  | out       | out_valid, out_stall| nack, frame_kind, mode_digit,
//          |           |                     | volume, speed, ratio, reverse_pct,
//          |           |                     | button_byte, move_byte
//
// Each byte is first captured in an input register; from there the parser
// logic updates the frame state and, for a byte that ends a frame, loads
// the result register. One byte is taken every cycle while the result side
// keeps up. The input stalls only when a byte waits in the input register
// and the result register holds a beat that is itself stalled.
// Reset is asynchronous and active low; afterwards the parser is idle and
// the stored values hold their defaults (mode 2, zeros, start bytes '0').

module ascii_command_frame_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        nack,
	output logic [1:0]  frame_kind,
	output logic [3:0]  mode_digit,
	output logic [13:0] volume,
	output logic [9:0]  speed,
	output logic [9:0]  ratio,
	output logic [9:0]  reverse_pct,
	output logic [7:0]  button_byte,
	output logic [7:0]  move_byte
);
	import acfp_pkg::*;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_DOSE,
		PH_WASH,
		PH_START
	} phase_t;

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Parser state.
	phase_t     phase_q;
	logic [3:0] digit_count_q;
	logic [3:0] pend_mode_q;
	logic [13:0] pend_volume_q;
	logic [9:0] pend_speed_q;
	logic [9:0] pend_ratio_q;
	logic [9:0] pend_reverse_q;
	param_set_t dose_q;
	param_set_t wash_q;
	logic [7:0] button_q;
	logic [7:0] move_q;

	// Result register.
	logic       out_valid_q;
	logic       nack_q;
	logic [1:0] kind_q;
	param_set_t res_set_q;
	logic [7:0] res_button_q;
	logic [7:0] res_move_q;

	// Next-state values from the parser logic.
	phase_t     phase_d;
	logic [3:0] digit_count_d;
	logic [3:0] pend_mode_d;
	logic [13:0] pend_volume_d;
	logic [9:0] pend_speed_d;
	logic [9:0] pend_ratio_d;
	logic [9:0] pend_reverse_d;
	param_set_t dose_d;
	param_set_t wash_d;
	logic [7:0] button_d;
	logic [7:0] move_d;
	logic       emit;
	logic       nack_d;
	logic [1:0] kind_d;
	param_set_t res_set_d;

	logic       advance;
	logic [3:0] digit_val;
	logic [3:0] count_inc;
	logic [3:0] frame_len;

	// The byte in the input register moves on whenever the result register
	// is free or is being emptied in this cycle.
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	assign digit_val = byte_s1[3:0];
	assign count_inc = digit_count_q + 4'd1;
	assign frame_len = (phase_q == PH_DOSE) ? DOSE_LEN : WASH_LEN;

	always_comb begin
		phase_d        = phase_q;
		digit_count_d  = digit_count_q;
		pend_mode_d    = pend_mode_q;
		pend_volume_d  = pend_volume_q;
		pend_speed_d   = pend_speed_q;
		pend_ratio_d   = pend_ratio_q;
		pend_reverse_d = pend_reverse_q;
		dose_d         = dose_q;
		wash_d         = wash_q;
		button_d       = button_q;
		move_d         = move_q;
		emit           = 1'b0;
		nack_d         = 1'b0;
		kind_d         = KIND_UNKNOWN;

		case (phase_q)
			PH_IDLE: begin
				if (byte_s1 == CH_AT) begin
					phase_d = PH_DOSE;
				end else if (byte_s1 == CH_P) begin
					phase_d = PH_WASH;
				end else if (byte_s1 == CH_EQ) begin
					phase_d = PH_START;
				end else if (byte_s1 != CH_CR && byte_s1 != CH_LF) begin
					// Unrecognised byte outside a frame: nack, nothing stored.
					emit   = 1'b1;
					nack_d = 1'b1;
					kind_d = KIND_UNKNOWN;
				end
			end
			PH_START: begin
				if (digit_count_q == 4'd0) begin
					button_d      = byte_s1;
					digit_count_d = 4'd1;
				end else begin
					// Both raw bytes are kept; the check only picks ack or nack.
					move_d = byte_s1;
					emit   = 1'b1;
					kind_d = KIND_START;
					nack_d = !(is_digit(button_q) && is_digit(byte_s1) &&
						(button_q <= CH_TWO));
				end
			end
			PH_DOSE, PH_WASH: begin
				kind_d = (phase_q == PH_DOSE) ? KIND_DOSE : KIND_WASH;
				if (!is_digit(byte_s1)) begin
					// Bad digit aborts the frame; stored values stay as they were.
					emit   = 1'b1;
					nack_d = 1'b1;
				end else begin
					// Mode takes its digit; other digits shift their field one decimal place.
					if (digit_count_q == POS_MODE) begin
						pend_mode_d = digit_val;
					end else if (digit_count_q <= POS_VOLUME) begin
						pend_volume_d = pend_volume_q * 14'd10 + 14'(digit_val);
					end else if (digit_count_q <= POS_SPEED) begin
						pend_speed_d = pend_speed_q * 10'd10 + 10'(digit_val);
					end else if (digit_count_q <= POS_RATIO && phase_q == PH_DOSE) begin
						pend_ratio_d = pend_ratio_q * 10'd10 + 10'(digit_val);
					end else begin
						pend_reverse_d = pend_reverse_q * 10'd10 + 10'(digit_val);
					end
					digit_count_d = count_inc;
					if (count_inc == frame_len) begin
						// Last digit: commit the whole frame at once.
						emit = 1'b1;
						if (phase_q == PH_DOSE) begin
							dose_d.mode    = pend_mode_d;
							dose_d.volume  = pend_volume_d;
							dose_d.speed   = pend_speed_d;
							dose_d.ratio   = pend_ratio_d;
							dose_d.reverse = pend_reverse_d;
						end else begin
							wash_d.mode    = pend_mode_d;
							wash_d.volume  = pend_volume_d;
							wash_d.speed   = pend_speed_d;
							wash_d.reverse = pend_reverse_d;
						end
					end
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase

		// Opening a frame or ending one clears the pending digits.
		if (emit || phase_q == PH_IDLE) begin
			if (emit) begin
				phase_d = PH_IDLE;
			end
			digit_count_d  = 4'd0;
			pend_mode_d    = 4'd0;
			pend_volume_d  = 14'd0;
			pend_speed_d   = 10'd0;
			pend_ratio_d   = 10'd0;
			pend_reverse_d = 10'd0;
		end

		// The result reports wash values for wash frames and dosing values
		// otherwise; the ratio always comes from the dosing set.
		res_set_d       = (kind_d == KIND_WASH) ? wash_d : dose_d;
		res_set_d.ratio = dose_d.ratio;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			byte_s1        <= 8'd0;
			phase_q        <= PH_IDLE;
			digit_count_q  <= 4'd0;
			pend_mode_q    <= 4'd0;
			pend_volume_q  <= 14'd0;
			pend_speed_q   <= 10'd0;
			pend_ratio_q   <= 10'd0;
			pend_reverse_q <= 10'd0;
			dose_q         <= '{mode: RESET_MODE, default: '0};
			wash_q         <= '{mode: RESET_MODE, default: '0};
			button_q       <= CH_ZERO;
			move_q         <= CH_ZERO;
			out_valid_q    <= 1'b0;
			nack_q         <= 1'b0;
			kind_q         <= KIND_DOSE;
			res_set_q      <= '0;
			res_button_q   <= 8'd0;
			res_move_q     <= 8'd0;
		end else begin
			if (in_valid && !in_stall) begin
				byte_s1 <= rx_byte;
			end
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end

			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (valid_s1 && advance) begin
				phase_q        <= phase_d;
				digit_count_q  <= digit_count_d;
				pend_mode_q    <= pend_mode_d;
				pend_volume_q  <= pend_volume_d;
				pend_speed_q   <= pend_speed_d;
				pend_ratio_q   <= pend_ratio_d;
				pend_reverse_q <= pend_reverse_d;
				dose_q         <= dose_d;
				wash_q         <= wash_d;
				button_q       <= button_d;
				move_q         <= move_d;
				if (emit) begin
					out_valid_q  <= 1'b1;
					nack_q       <= nack_d;
					kind_q       <= kind_d;
					res_set_q    <= res_set_d;
					res_button_q <= button_d;
					res_move_q   <= move_d;
				end
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign nack        = nack_q;
	assign frame_kind  = kind_q;
	assign mode_digit  = res_set_q.mode;
	assign volume      = res_set_q.volume;
	assign speed       = res_set_q.speed;
	assign ratio       = res_set_q.ratio;
	assign reverse_pct = res_set_q.reverse;
	assign button_byte = res_button_q;
	assign move_byte   = res_move_q;

	// An unrecognised byte can only ever be reported as a nack.
	a_unknown_is_nack: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q == KIND_UNKNOWN |-> nack_q)
		else $error("unrecognised byte reported as ack");

	// The digit counter never reaches the longest frame length.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		digit_count_q < DOSE_LEN)
		else $error("digit counter out of range");

	// A start frame holds at most its button byte between beats.
	a_start_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_START |-> digit_count_q <= 4'd1)
		else $error("start frame counter out of range");

	// The input only stalls with a byte held behind a stalled result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled without cause");

	// Reported decimal values stay within their digit counts.
	a_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> res_set_q.volume <= 14'd9999 && res_set_q.speed <= 10'd999 &&
			res_set_q.ratio <= 10'd999 && res_set_q.reverse <= 10'd999)
		else $error("reported value out of decimal range");

endmodule
